// ===== design/imul_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imul_pkg
// Shared types, constants and helpers for the interval multiply unit.
// ----------------------------------------------------------------------------
package imul_pkg;

    localparam logic [63:0] C_SIGN_BIT    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] C_MAG_MASK    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] C_EXP_INF     = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] C_QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] C_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] C_MAX_FINITE  = 64'h7FEF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] a_lo;
        logic [63:0] a_hi;
        logic [63:0] b_lo;
        logic [63:0] b_hi;
    } t_in_req;

    typedef struct packed {
        logic [63:0] prod_lo;
        logic [63:0] prod_hi;
    } t_out_req;

    // operand pair and rounding direction for one product
    typedef struct packed {
        logic [63:0] x;
        logic [63:0] y;
        logic        up;
    } t_mul_op;

    // selection control from the case decoder to the final stage
    typedef struct packed {
        logic both_oth;
    } t_sel_ctl;

    function automatic logic f_is_nan(input logic [63:0] v);
        return (v & C_MAG_MASK) > C_EXP_INF;
    endfunction

    function automatic logic f_is_pos(input logic [63:0] v);
        return !f_is_nan(v) && !v[63] && (v[62:0] != 63'd0);
    endfunction

    function automatic logic f_is_neg(input logic [63:0] v);
        return !f_is_nan(v) && v[63] && (v[62:0] != 63'd0);
    endfunction

    function automatic logic f_less(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] kx;
        logic [63:0] ky;
        kx = x[63] ? ~x : (x | C_SIGN_BIT);
        ky = y[63] ? ~y : (y | C_SIGN_BIT);
        if (f_is_nan(x) || f_is_nan(y)) begin
            return 1'b0;
        end
        if (x[62:0] == 63'd0 && y[62:0] == 63'd0) begin
            return 1'b0;
        end
        return kx < ky;
    endfunction

endpackage
`default_nettype wire

// ===== design/interval_multiply_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_multiply_unit
// Product of two binary64 intervals with outward directed rounding.
// ----------------------------------------------------------------------------
// path from accepted request to output (5 multiplier stages,
//   then one register that does the max/min select and holds the output)
// throughput: one request per cycle; set by the four parallel multiplier pipes
// a stall freezes the whole pipe; the input stalls while a valid output is stalled
// reset clears the stage valid bits only
module interval_multiply_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  imul_pkg::t_in_req     i_req,
    output logic                  o_valid,
    input  wire                   i_stall,
    output imul_pkg::t_out_req    o_req
);
    import imul_pkg::*;

    localparam int unsigned C_MUL_STAGES = 5;

    t_mul_op  w_hi0, w_hi1, w_lo0, w_lo1;
    t_sel_ctl w_ctl;
    logic [63:0] w_rhi0, w_rhi1, w_rlo0, w_rlo1;

    logic [C_MUL_STAGES-1:0] r_vld;
    t_sel_ctl                r_ctl [C_MUL_STAGES];
    logic                    r_out_vld;
    t_out_req                r_out;
    logic                    w_en;

    // pipe advances unless a result sits at the output and is stalled
    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = !w_en;

    imul_decode u_dec (
        .i_req (i_req),
        .o_hi0 (w_hi0),
        .o_hi1 (w_hi1),
        .o_lo0 (w_lo0),
        .o_lo1 (w_lo1),
        .o_ctl (w_ctl)
    );

    imul_fmul u_mhi0 (.i_clk(i_clk), .i_en(w_en), .i_op(w_hi0), .o_res(w_rhi0));
    imul_fmul u_mhi1 (.i_clk(i_clk), .i_en(w_en), .i_op(w_hi1), .o_res(w_rhi1));
    imul_fmul u_mlo0 (.i_clk(i_clk), .i_en(w_en), .i_op(w_lo0), .o_res(w_rlo0));
    imul_fmul u_mlo1 (.i_clk(i_clk), .i_en(w_en), .i_op(w_lo1), .o_res(w_rlo1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[C_MUL_STAGES-2:0], i_valid};
            r_out_vld <= r_vld[C_MUL_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl[0] <= w_ctl;
            for (int i = 1; i < C_MUL_STAGES; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    t_out_req n_out;
    always_comb begin
        n_out.prod_hi = w_rhi0;
        n_out.prod_lo = w_rlo0;
        if (r_ctl[C_MUL_STAGES-1].both_oth) begin
            if (f_less(w_rhi0, w_rhi1)) begin
                n_out.prod_hi = w_rhi1;
            end
            if (f_less(w_rlo1, w_rlo0)) begin
                n_out.prod_lo = w_rlo1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_req   = r_out;

endmodule
`default_nettype wire

// ===== design/imul_fmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imul_fmul
// Pipelined binary64 multiplier with directed rounding (toward +inf or -inf).
// Stage 1 unpack and normalize, stage 2 partial products, stage 3 sum,
// stage 4 exponent and shift amount, stage 5 shift and round.
// Advances when i_en is high.
// ----------------------------------------------------------------------------
module imul_fmul (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  imul_pkg::t_mul_op    i_op,
    output logic [63:0]          o_res
);
    import imul_pkg::*;

    // ---------------- stage 1: classify and unpack ----------------
    logic        n1_special;
    logic [63:0] n1_spec_val;
    logic        n1_sign;
    logic        n1_away;
    logic [52:0] n1_ma;
    logic [52:0] n1_mb;
    logic signed [13:0] n1_ea;
    logic signed [13:0] n1_eb;
    logic [5:0]  n1_lza;
    logic [5:0]  n1_lzb;

    logic        r1_special;
    logic [63:0] r1_spec_val;
    logic        r1_sign;
    logic        r1_away;
    logic [52:0] r1_ma;
    logic [52:0] r1_mb;
    logic signed [13:0] r1_esum;

    function automatic logic [5:0] f_lz(input logic [51:0] f);
        logic [5:0] n;
        logic       hit;
        n   = 6'd0;
        hit = 1'b0;
        for (int i = 51; i >= 0; i--) begin
            if (!hit) begin
                if (f[i]) begin
                    hit = 1'b1;
                end else begin
                    n = n + 6'd1;
                end
            end
        end
        return n;
    endfunction

    always_comb begin
        logic [63:0] ma;
        logic [63:0] mb;
        ma          = i_op.x & C_MAG_MASK;
        mb          = i_op.y & C_MAG_MASK;
        n1_sign     = i_op.x[63] ^ i_op.y[63];
        n1_away     = i_op.up ? !n1_sign : n1_sign;
        n1_special  = 1'b1;
        n1_spec_val = {n1_sign, 63'd0};
        if (f_is_nan(i_op.x)) begin
            n1_spec_val = i_op.x | C_QUIET_BIT;
        end else if (f_is_nan(i_op.y)) begin
            n1_spec_val = i_op.y | C_QUIET_BIT;
        end else if (ma == C_EXP_INF || mb == C_EXP_INF) begin
            if (ma == 64'd0 || mb == 64'd0) begin
                n1_spec_val = C_DEFAULT_NAN;
            end else begin
                n1_spec_val = {n1_sign, C_EXP_INF[62:0]};
            end
        end else if (ma == 64'd0 || mb == 64'd0) begin
            n1_spec_val = {n1_sign, 63'd0};
        end else begin
            n1_special = 1'b0;
        end
        // subnormals normalized so bit 52 is set
        n1_lza = f_lz(i_op.x[51:0]);
        n1_lzb = f_lz(i_op.y[51:0]);
        if (i_op.x[62:52] == 11'd0) begin
            n1_ma = {i_op.x[51:0], 1'b0} << n1_lza;
            n1_ea = 14'sd0 - $signed({8'd0, n1_lza});
        end else begin
            n1_ma = {1'b1, i_op.x[51:0]};
            n1_ea = $signed({3'd0, i_op.x[62:52]});
        end
        if (i_op.y[62:52] == 11'd0) begin
            n1_mb = {i_op.y[51:0], 1'b0} << n1_lzb;
            n1_eb = 14'sd0 - $signed({8'd0, n1_lzb});
        end else begin
            n1_mb = {1'b1, i_op.y[51:0]};
            n1_eb = $signed({3'd0, i_op.y[62:52]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_special  <= n1_special;
            r1_spec_val <= n1_spec_val;
            r1_sign     <= n1_sign;
            r1_away     <= n1_away;
            r1_ma       <= n1_ma;
            r1_mb       <= n1_mb;
            r1_esum     <= n1_ea + n1_eb;
        end
    end

    // ---------------- stage 2: four partial products of 27/26-bit halves ----------------
    logic [53:0] r2_p00;
    logic [53:0] r2_p01;
    logic [53:0] r2_p10;
    logic [51:0] r2_p11;
    logic        r2_special;
    logic [63:0] r2_spec_val;
    logic        r2_sign;
    logic        r2_away;
    logic signed [13:0] r2_esum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p00      <= {27'd0, r1_ma[26:0]} * {27'd0, r1_mb[26:0]};
            r2_p01      <= {27'd0, r1_ma[26:0]} * {28'd0, r1_mb[52:27]};
            r2_p10      <= {28'd0, r1_ma[52:27]} * {27'd0, r1_mb[26:0]};
            r2_p11      <= {26'd0, r1_ma[52:27]} * {26'd0, r1_mb[52:27]};
            r2_special  <= r1_special;
            r2_spec_val <= r1_spec_val;
            r2_sign     <= r1_sign;
            r2_away     <= r1_away;
            r2_esum     <= r1_esum;
        end
    end

    // ---------------- stage 3: sum partial products ----------------
    logic [105:0] r3_prod;
    logic         r3_special;
    logic [63:0]  r3_spec_val;
    logic         r3_sign;
    logic         r3_away;
    logic signed [13:0] r3_esum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_prod     <= {52'd0, r2_p00} + ({52'd0, r2_p01} << 27)
                         + ({52'd0, r2_p10} << 27) + ({r2_p11, 54'd0});
            r3_special  <= r2_special;
            r3_spec_val <= r2_spec_val;
            r3_sign     <= r2_sign;
            r3_away     <= r2_away;
            r3_esum     <= r2_esum;
        end
    end

    // ---------------- stage 4: exponent and shift amount ----------------
    logic [105:0] r4_prod;
    logic [7:0]   r4_total;
    logic [10:0]  r4_exp;
    logic         r4_ovf;
    logic         r4_special;
    logic [63:0]  r4_spec_val;
    logic         r4_sign;
    logic         r4_away;

    logic signed [13:0] n4_e;
    logic signed [13:0] n4_total;
    logic [5:0]         n4_shift;

    always_comb begin
        n4_shift = r3_prod[105] ? 6'd53 : 6'd52;
        n4_e     = $signed({8'd0, n4_shift}) + r3_esum - 14'sd1075;
        n4_total = $signed({8'd0, n4_shift});
        if (n4_e < 14'sd1) begin
            n4_total = n4_total + 14'sd1 - n4_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_prod     <= r3_prod;
            r4_ovf      <= n4_e >= 14'sd2047;
            r4_exp      <= (n4_e < 14'sd1) ? 11'd0 : n4_e[10:0] - 11'd1;
            r4_total    <= (n4_total > 14'sd127) ? 8'd127 : n4_total[7:0];
            r4_special  <= r3_special;
            r4_spec_val <= r3_spec_val;
            r4_sign     <= r3_sign;
            r4_away     <= r3_away;
        end
    end

    // ---------------- stage 5: shift, round, pack ----------------
    logic [63:0] r5_res;
    logic [105:0] n5_sh;
    logic         n5_sticky;
    logic [63:0]  n5_res;

    always_comb begin
        n5_sh     = r4_prod >> r4_total[6:0];
        n5_sticky = (r4_prod & ~({106{1'b1}} << r4_total[6:0])) != 106'd0;
        if (r4_special) begin
            n5_res = r4_spec_val;
        end else if (r4_ovf) begin
            n5_res = {r4_sign, r4_away ? C_EXP_INF[62:0] : C_MAX_FINITE[62:0]};
        end else begin
            n5_res = {r4_sign, ({r4_exp, 52'd0} + n5_sh[62:0]
                     + {62'd0, n5_sticky && r4_away})};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_res <= n5_res;
        end
    end

    assign o_res = r5_res;

endmodule
`default_nettype wire

// ===== design/imul_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imul_decode
// Classifies both intervals and picks the four bound products.
// ----------------------------------------------------------------------------
module imul_decode (
    input  imul_pkg::t_in_req   i_req,
    output imul_pkg::t_mul_op   o_hi0,
    output imul_pkg::t_mul_op   o_hi1,
    output imul_pkg::t_mul_op   o_lo0,
    output imul_pkg::t_mul_op   o_lo1,
    output imul_pkg::t_sel_ctl  o_ctl
);
    import imul_pkg::*;

    logic a_pos, a_neg, b_pos, b_neg;

    always_comb begin
        a_pos = f_is_pos(i_req.a_lo);
        a_neg = f_is_neg(i_req.a_hi);
        b_pos = f_is_pos(i_req.b_lo);
        b_neg = f_is_neg(i_req.b_hi);
        o_ctl.both_oth = 1'b0;
        // second products only matter when both straddle zero
        o_hi1 = '{x: i_req.a_lo, y: i_req.b_lo, up: 1'b1};
        o_lo1 = '{x: i_req.a_hi, y: i_req.b_lo, up: 1'b0};
        if (a_pos) begin
            if (b_pos) begin
                o_hi0 = '{x: i_req.a_hi, y: i_req.b_hi, up: 1'b1};
                o_lo0 = '{x: i_req.a_lo, y: i_req.b_lo, up: 1'b0};
            end else if (b_neg) begin
                o_hi0 = '{x: i_req.a_lo, y: i_req.b_hi, up: 1'b1};
                o_lo0 = '{x: i_req.a_hi, y: i_req.b_lo, up: 1'b0};
            end else begin
                o_hi0 = '{x: i_req.a_hi, y: i_req.b_hi, up: 1'b1};
                o_lo0 = '{x: i_req.a_hi, y: i_req.b_lo, up: 1'b0};
            end
        end else if (a_neg) begin
            if (b_neg) begin
                o_hi0 = '{x: i_req.a_lo, y: i_req.b_lo, up: 1'b1};
                o_lo0 = '{x: i_req.a_hi, y: i_req.b_hi, up: 1'b0};
            end else if (b_pos) begin
                o_hi0 = '{x: i_req.a_hi, y: i_req.b_lo, up: 1'b1};
                o_lo0 = '{x: i_req.a_lo, y: i_req.b_hi, up: 1'b0};
            end else begin
                o_hi0 = '{x: i_req.a_lo, y: i_req.b_lo, up: 1'b1};
                o_lo0 = '{x: i_req.a_lo, y: i_req.b_hi, up: 1'b0};
            end
        end else begin
            if (b_pos) begin
                o_hi0 = '{x: i_req.a_hi, y: i_req.b_hi, up: 1'b1};
                o_lo0 = '{x: i_req.a_lo, y: i_req.b_hi, up: 1'b0};
            end else if (b_neg) begin
                o_hi0 = '{x: i_req.a_lo, y: i_req.b_lo, up: 1'b1};
                o_lo0 = '{x: i_req.a_hi, y: i_req.b_lo, up: 1'b0};
            end else begin
                o_hi0 = '{x: i_req.a_hi, y: i_req.b_hi, up: 1'b1};
                o_lo0 = '{x: i_req.a_lo, y: i_req.b_hi, up: 1'b0};
                o_ctl.both_oth = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire
